[rtl/core/hbit_pkg.sv]
// Shared types and codes for the bucketed hash index table.
package hbit_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_INSERT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DONE
  } state_t;

endpackage

[rtl/core/hbit_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module hbit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/bucketed_hash_index_table_top.sv]
// Top level of the bucketed hash index table: sequencer, fill-count RAM and slot RAM.
//
// Usage:
//   Input stream (s_*): tuser is the operation (0 insert, 1 lookup), tdata carries
//   key_hash and player_index. The low BUCKET_BITS of key_hash pick the bucket.
//   Output stream (m_*): tuser is the status, tdata the found index, tlast marks the
//   final result of a transaction. An insert answers once; a lookup answers once
//   per matching slot in fill order, or once with "no candidate".
// Timing:
//   One item at a time. An insert reads the bucket's fill count, then in S_INSERT
//   writes the slot if the bucket has room and loads the result. A lookup reads
//   the fill count, then checks the bucket's slots in turn, each by a slot RAM
//   read and then a compare, and loads its last result in S_DONE. s_tready is
//   high only while the block is idle.
// Reset:
//   rst clears control state, then a clearing pass writes every bucket's fill
//   count to zero, one bucket per cycle. s_tready stays low during that pass.
// Stall:
//   The output register holds a result until m_tready; the scan waits on it.
module bucketed_hash_index_table_top #(
  parameter int BUCKET_BITS      = 12,
  parameter int SLOTS_PER_BUCKET = 8,
  parameter int INDEX_BITS       = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [55:0]      s_tdata,   // [31:0] key_hash, [51:32] player_index, [55:52] zero
  input  logic             s_tuser,   // [0] operation
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,   // [19:0] found_index, [23:20] zero
  output hbit_pkg::status_t m_tuser,  // [1:0] status
  output logic             m_tlast
);

  import hbit_pkg::*;

  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int NUM_SLOTS   = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int ADDR_W      = $clog2(NUM_SLOTS);
  localparam int FW          = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int SW          = 32 + INDEX_BITS;
  localparam logic [FW-1:0]          SLOTS_CNT = FW'(SLOTS_PER_BUCKET);
  localparam logic [ADDR_W-1:0]      SLOTS_A   = ADDR_W'(SLOTS_PER_BUCKET);
  localparam logic [BUCKET_BITS-1:0] LAST_BKT  = '1;

  state_t state, state_next;

  logic [BUCKET_BITS-1:0] clr_addr;
  logic                   op;
  logic [31:0]            key;
  logic [INDEX_BITS-1:0]  pidx;
  logic [FW-1:0]          fill;
  logic [FW-1:0]          slot;
  logic                   pend_valid;
  logic [19:0]            pend_index;

  logic [BUCKET_BITS-1:0] bucket;
  logic [ADDR_W-1:0]      base;
  logic [63:0]            pidx_wide;

  logic                   out_free;
  logic                   out_load;
  status_t                out_status;
  logic [19:0]            res_index;
  logic                   out_last;
  logic [19:0]            m_index;

  logic                   fill_re, fill_we;
  logic [BUCKET_BITS-1:0] fill_waddr;
  logic [FW-1:0]          fill_wdata, fill_rdata;
  logic                   slot_re, slot_we;
  logic [SW-1:0]          slot_rdata;
  logic [63:0]            hit_wide;
  logic                   hit;
  logic                   slot_inc, pend_set;

  assign bucket    = key[BUCKET_BITS-1:0];
  assign base      = ADDR_W'(bucket) * SLOTS_A;
  assign pidx_wide = 64'(s_tdata[51:32]);
  assign hit       = (slot_rdata[31:0] == key);
  assign hit_wide  = 64'(slot_rdata[SW-1:32]);
  assign out_free  = !m_tvalid || m_tready;

  assign fill_waddr = (state == S_CLEAR) ? clr_addr : bucket;
  assign fill_wdata = (state == S_CLEAR) ? '0 : fill + FW'(1);

  hbit_ram #(.WIDTH(FW), .DEPTH(NUM_BUCKETS)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (fill_re),
    .raddr (s_tdata[BUCKET_BITS-1:0]),
    .rdata (fill_rdata)
  );

  hbit_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (base + ADDR_W'(fill)),
    .wdata ({pidx, key}),
    .re    (slot_re),
    .raddr (base + ADDR_W'(slot)),
    .rdata (slot_rdata)
  );

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    fill_re    = 1'b0;
    fill_we    = 1'b0;
    slot_re    = 1'b0;
    slot_we    = 1'b0;
    out_load   = 1'b0;
    out_status = ST_NONE;
    res_index  = '0;
    out_last   = 1'b1;
    slot_inc   = 1'b0;
    pend_set   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        fill_we = 1'b1;
        if (clr_addr == LAST_BKT) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          fill_re    = 1'b1;
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        state_next = (op == OP_LOOKUP) ? S_SCAN_RD : S_INSERT;
      end
      S_INSERT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (fill < SLOTS_CNT) begin
            slot_we    = 1'b1;
            fill_we    = 1'b1;
            out_status = ST_INSERTED;
          end else begin
            out_status = ST_FULL;
          end
        end
      end
      S_SCAN_RD: begin
        if (slot == fill) begin
          state_next = S_DONE;
        end else begin
          slot_re    = 1'b1;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (!hit) begin
          slot_inc   = 1'b1;
          state_next = S_SCAN_RD;
        end else if (!pend_valid || out_free) begin
          // earlier match goes out now; the newest one is held until we know if it is last
          pend_set   = 1'b1;
          slot_inc   = 1'b1;
          state_next = S_SCAN_RD;
          if (pend_valid) begin
            out_load   = 1'b1;
            out_status = ST_FOUND;
            res_index  = pend_index;
            out_last   = 1'b0;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (pend_valid) begin
            out_status = ST_FOUND;
            res_index  = pend_index;
          end
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + BUCKET_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        pend_valid <= 1'b0;
      end else if (pend_set) begin
        pend_valid <= 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op   <= s_tuser;
      key  <= s_tdata[31:0];
      pidx <= pidx_wide[INDEX_BITS-1:0];
    end
    if (state == S_FILL) begin
      fill <= fill_rdata;
      slot <= '0;
    end else if (slot_inc) begin
      slot <= slot + FW'(1);
    end
    if (pend_set) begin
      pend_index <= hit_wide[19:0];
    end
    if (out_load) begin
      m_tuser <= out_status;
      m_index <= res_index;
      m_tlast <= out_last;
    end
  end

  assign m_tdata = {4'b0, m_index};

  a_single_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in progress");

  a_zero_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_FOUND |-> m_tdata == 24'd0)
    else $error("non-candidate result carries an index");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_FOUND |-> m_tlast)
    else $error("non-candidate result is not last");

  a_no_idle_result: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !m_tvalid)
    else $error("result shown during clearing pass");

endmodule
